[rtl/pid_windowed_integral_controller_macros.svh]
// Assertion macros used by the port-level checker.
// Each expands to one labelled concurrent assertion, clocked on the rising
// edge and switched off while reset is high.
`ifndef PID_WINDOWED_INTEGRAL_CONTROLLER_MACROS_SVH
`define PID_WINDOWED_INTEGRAL_CONTROLLER_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define PWIC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define PWIC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/pwic_pkg.sv]
package pwic_pkg;

  // field widths
  localparam int REVS_W      = 32;
  localparam int ERR_W       = 24;
  localparam int STOP_W      = 23;
  localparam int GAIN_W      = 16;
  localparam int CMD_W       = 8;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;
  // right shift that drops fraction bits from the command and the position product
  localparam int FRAC_W      = 16;

  // request queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // saturation limits
  localparam logic signed [ERR_W-1:0] ERR_MAX   = {1'b0, {(ERR_W-1){1'b1}}};
  localparam logic signed [ERR_W-1:0] ERR_MIN   = {1'b1, {(ERR_W-1){1'b0}}};
  localparam logic signed [CMD_W-1:0] CMD_LIMIT = CMD_W'(100);

  // register reset values
  localparam logic signed [ERR_W-1:0] TARGET_RST = '0;
  localparam logic [STOP_W-1:0]       STOP_RST   = STOP_W'(256);
  localparam logic [GAIN_W-1:0]       GAIN_P_RST = GAIN_W'(4267);
  localparam logic [GAIN_W-1:0]       GAIN_I_RST = GAIN_W'(1280);
  localparam logic [GAIN_W-1:0]       GAIN_D_RST = GAIN_W'(3413);
  localparam logic [GAIN_W-1:0]       TRAVEL_RST = GAIN_W'(2614);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET = 3'd0,
    CFG_STOP   = 3'd1,
    CFG_GAIN_P = 3'd2,
    CFG_GAIN_I = 3'd3,
    CFG_GAIN_D = 3'd4,
    CFG_TRAVEL = 3'd5
  } cfg_idx_t;

  // request class set by the front
  typedef enum logic {
    OP_TRACK,
    OP_RESTART
  } op_t;

  typedef struct packed {
    logic signed [ERR_W-1:0] target;
    logic [STOP_W-1:0]       stop_band;
    logic [GAIN_W-1:0]       gain_p;
    logic [GAIN_W-1:0]       gain_i;
    logic [GAIN_W-1:0]       gain_d;
    logic [GAIN_W-1:0]       travel_per_rev;
  } cfg_t;

  typedef struct packed {
    op_t                      op;
    logic signed [REVS_W-1:0] measured_revs;
  } req_t;

  typedef struct packed {
    logic signed [CMD_W-1:0] drive_command;
    logic                    move_done;
    logic signed [ERR_W-1:0] current_error;
  } res_t;

endpackage

[rtl/pwic_in_if.sv]
// sample channel
interface pwic_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [pwic_pkg::REVS_W-1:0] measured_revs;
  logic                               first_sample;

  modport source (output valid, output measured_revs, output first_sample, input ready);
  modport sink   (input valid, input measured_revs, input first_sample, output ready);
endinterface

[rtl/pwic_out_if.sv]
// result channel
interface pwic_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [pwic_pkg::CMD_W-1:0] drive_command;
  logic                              move_done;
  logic signed [pwic_pkg::ERR_W-1:0] current_error;

  modport source (output valid, output drive_command, output move_done,
                  output current_error, input ready);
  modport sink   (input valid, input drive_command, input move_done,
                  input current_error, output ready);
endinterface

[rtl/pwic_cfg_if.sv]
// register write channel
interface pwic_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [pwic_pkg::CFG_IDX_W-1:0]   index;
  logic [pwic_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/pwic_ram.sv]
// Generic single write port RAM with registered read.
module pwic_ram #(
  parameter int  WIDTH = 24,
  parameter int  DEPTH = 25,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic               clk,
  input  logic               we,
  input  logic [AW-1:0]      waddr,
  input  logic [WIDTH-1:0]   wdata,
  input  logic [AW-1:0]      raddr,
  output logic [WIDTH-1:0]   rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[rtl/pwic_front.sv]
// Front: register file writes and sample intake, tagging restart requests.
module pwic_front (
  input  logic              clk,
  input  logic              rst,
  pwic_in_if.sink           in_ch,
  pwic_cfg_if.sink          cfg,
  input  logic              q_full,
  output logic              push,
  output pwic_pkg::req_t    push_req,
  output pwic_pkg::cfg_t    regs
);

  // register writes are always accepted
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.target         <= pwic_pkg::TARGET_RST;
      regs.stop_band      <= pwic_pkg::STOP_RST;
      regs.gain_p         <= pwic_pkg::GAIN_P_RST;
      regs.gain_i         <= pwic_pkg::GAIN_I_RST;
      regs.gain_d         <= pwic_pkg::GAIN_D_RST;
      regs.travel_per_rev <= pwic_pkg::TRAVEL_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        pwic_pkg::CFG_TARGET: begin
          regs.target <= $signed(cfg.data[pwic_pkg::ERR_W-1:0]);
        end
        pwic_pkg::CFG_STOP: begin
          regs.stop_band <= cfg.data[pwic_pkg::STOP_W-1:0];
        end
        pwic_pkg::CFG_GAIN_P: begin
          regs.gain_p <= cfg.data[pwic_pkg::GAIN_W-1:0];
        end
        pwic_pkg::CFG_GAIN_I: begin
          regs.gain_i <= cfg.data[pwic_pkg::GAIN_W-1:0];
        end
        pwic_pkg::CFG_GAIN_D: begin
          regs.gain_d <= cfg.data[pwic_pkg::GAIN_W-1:0];
        end
        pwic_pkg::CFG_TRAVEL: begin
          regs.travel_per_rev <= cfg.data[pwic_pkg::GAIN_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // sample intake: a request is taken whenever the queue has room
  assign in_ch.ready            = !q_full;
  assign push                   = in_ch.valid && !q_full;
  assign push_req.op            = in_ch.first_sample ? pwic_pkg::OP_RESTART
                                                     : pwic_pkg::OP_TRACK;
  assign push_req.measured_revs = in_ch.measured_revs;

endmodule

[rtl/pwic_queue.sv]
// Short request queue decoupling intake from the sequencer.
module pwic_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  pwic_pkg::req_t  push_req,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output pwic_pkg::req_t  head
);

  pwic_pkg::req_t                entries [pwic_pkg::QUEUE_DEPTH];
  logic [pwic_pkg::QPTR_W-1:0]   wr_ptr;
  logic [pwic_pkg::QPTR_W-1:0]   rd_ptr;
  logic [pwic_pkg::QPTR_W:0]     count;

  assign full       = (count == (pwic_pkg::QPTR_W+1)'(pwic_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_req;
    end
  end

endmodule

[rtl/pwic_back.sv]
// Back: control-law sequencer around one shared signed multiplier.
module pwic_back #(
  parameter int WINDOW = 25
) (
  input  logic            clk,
  input  logic            rst,
  input  pwic_pkg::cfg_t  regs,
  input  logic            q_valid,
  input  pwic_pkg::req_t  q_req,
  output logic            q_pop,
  output logic            res_valid,
  input  logic            res_ready,
  output pwic_pkg::res_t  res
);
  localparam int PTR_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUM_W   = pwic_pkg::ERR_W + $clog2(WINDOW);
  localparam int RECIP_W = SUM_W + 1;
  localparam int DIFF_W  = pwic_pkg::ERR_W + 1;
  localparam int ACC_W   = SUM_W + pwic_pkg::GAIN_W + 3;
  localparam int MUL_A_W = ((pwic_pkg::REVS_W > SUM_W) ? pwic_pkg::REVS_W : SUM_W) + 1;
  localparam int MUL_B_W = ((pwic_pkg::GAIN_W > RECIP_W) ? pwic_pkg::GAIN_W : RECIP_W) + 1;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  // floor(2^SUM_W / WINDOW): the mean is |sum| * RECIP >> SUM_W, then one fix-up
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << SUM_W) / WINDOW);
  localparam logic [PTR_W-1:0]   PTR_LAST = PTR_W'(WINDOW - 1);

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_ERR,
    ST_SUM,
    ST_MAG,
    ST_RCP,
    ST_FIX,
    ST_MULI,
    ST_OUT
  } state_t;

  state_t                           state;
  logic [WINDOW-1:0]                valid;
  logic [PTR_W-1:0]                 ptr;
  logic signed [SUM_W-1:0]          sum;
  logic signed [pwic_pkg::ERR_W-1:0] prev;
  logic signed [pwic_pkg::ERR_W-1:0] err;
  logic                             done;
  logic                             old_valid;
  logic signed [DIFF_W-1:0]         diff;
  logic [SUM_W-1:0]                 mag;
  logic [SUM_W-1:0]                 quot;
  logic signed [ACC_W-1:0]          acc;
  logic signed [PROD_W-1:0]         prod;

  logic                             restart;
  logic                             out_free;
  logic [PTR_W-1:0]                 raddr;
  logic [pwic_pkg::ERR_W-1:0]       rdata;
  logic signed [MUL_A_W-1:0]        mul_a;
  logic signed [MUL_B_W-1:0]        mul_b;
  logic signed [PROD_W-1:0]         prod_next;
  logic signed [pwic_pkg::REVS_W-1:0] distance;
  logic signed [pwic_pkg::REVS_W+1:0] err_wide;
  logic signed [pwic_pkg::ERR_W-1:0] err_next;
  logic signed [pwic_pkg::ERR_W-1:0] old_err;
  logic signed [SUM_W-1:0]          sum_next;
  logic [pwic_pkg::ERR_W:0]         abs_err;
  logic [SUM_W-1:0]                 mag_next;
  logic [SUM_W-1:0]                 q0;
  logic [SUM_W-1:0]                 rem;
  logic [SUM_W-1:0]                 quot_next;
  logic signed [ACC_W-1:0]          total;
  logic signed [ACC_W-1:0]          total_adj;
  logic signed [ACC_W-1:0]          cmd_wide;
  logic signed [pwic_pkg::CMD_W-1:0] cmd_next;

  assign restart  = (q_req.op == pwic_pkg::OP_RESTART);
  assign out_free = !res_valid || res_ready;
  assign q_pop    = (state == ST_LOAD) && q_valid;

  // error window, read at the slot about to be replaced
  assign raddr = (state == ST_LOAD && restart) ? '0 : ptr;

  pwic_ram #(
    .WIDTH (pwic_pkg::ERR_W),
    .DEPTH (WINDOW)
  ) u_window (
    .clk   (clk),
    .we    (state == ST_SUM),
    .waddr (ptr),
    .wdata (err),
    .raddr (raddr),
    .rdata (rdata)
  );

  // shared multiplier operand select; the I product is held while the result waits
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state) inside
      ST_LOAD: begin
        mul_a = MUL_A_W'(q_req.measured_revs);
        mul_b = $signed(MUL_B_W'(regs.travel_per_rev));
      end
      ST_SUM: begin
        mul_a = MUL_A_W'(err);
        mul_b = $signed(MUL_B_W'(regs.gain_p));
      end
      ST_MAG: begin
        mul_a = MUL_A_W'(diff);
        mul_b = $signed(MUL_B_W'(regs.gain_d));
      end
      ST_RCP: begin
        mul_a = $signed(MUL_A_W'(mag));
        mul_b = $signed(MUL_B_W'(RECIP));
      end
      ST_MULI, ST_OUT: begin
        mul_a = $signed(sum[SUM_W-1] ? -MUL_A_W'(quot) : MUL_A_W'(quot));
        mul_b = $signed(MUL_B_W'(regs.gain_i));
      end
      default: begin
      end
    endcase
  end

  assign prod_next = mul_a * mul_b;

  // distance (floor of the Q24.24 product) and saturated error
  assign distance = $signed(prod[pwic_pkg::REVS_W+pwic_pkg::FRAC_W-1:pwic_pkg::FRAC_W]);
  assign err_wide = (pwic_pkg::REVS_W+2)'(regs.target) - (pwic_pkg::REVS_W+2)'(distance);

  always_comb begin
    if (err_wide > (pwic_pkg::REVS_W+2)'(pwic_pkg::ERR_MAX)) begin
      err_next = pwic_pkg::ERR_MAX;
    end else if (err_wide < (pwic_pkg::REVS_W+2)'(pwic_pkg::ERR_MIN)) begin
      err_next = pwic_pkg::ERR_MIN;
    end else begin
      err_next = pwic_pkg::ERR_W'(err_wide);
    end
  end

  // running sum update; an unwritten slot counts as zero
  assign old_err  = old_valid ? $signed(rdata) : '0;
  assign sum_next = sum - SUM_W'(old_err) + SUM_W'(err);
  assign abs_err  = err[pwic_pkg::ERR_W-1] ? (pwic_pkg::ERR_W+1)'(-(pwic_pkg::ERR_W+1)'(err))
                                           : (pwic_pkg::ERR_W+1)'(err);
  assign mag_next = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);

  // reciprocal quotient is at most one short
  assign q0        = prod[SUM_W +: SUM_W];
  assign rem       = mag - q0 * SUM_W'(WINDOW);
  assign quot_next = (rem >= SUM_W'(WINDOW)) ? q0 + SUM_W'(1) : q0;

  // command: truncate toward zero, then clamp
  assign total     = acc + ACC_W'(prod);
  assign total_adj = total[ACC_W-1] ? total + ACC_W'((1 << pwic_pkg::FRAC_W) - 1) : total;
  assign cmd_wide  = total_adj >>> pwic_pkg::FRAC_W;

  always_comb begin
    if (cmd_wide > ACC_W'(pwic_pkg::CMD_LIMIT)) begin
      cmd_next = pwic_pkg::CMD_LIMIT;
    end else if (cmd_wide < -ACC_W'(pwic_pkg::CMD_LIMIT)) begin
      cmd_next = -pwic_pkg::CMD_LIMIT;
    end else begin
      cmd_next = pwic_pkg::CMD_W'(cmd_wide);
    end
  end

  // sequencer, window state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      valid     <= '0;
      ptr       <= '0;
      sum       <= '0;
      prev      <= '0;
      res_valid <= 1'b0;
    end else begin
      prod <= prod_next;
      if (state == ST_OUT && out_free) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end

      unique case (state)
        ST_LOAD: begin
          if (q_valid) begin
            if (restart) begin
              valid <= '0;
              sum   <= '0;
              ptr   <= '0;
              prev  <= regs.target;
            end
            old_valid <= !restart && valid[ptr];
            state     <= ST_ERR;
          end
        end
        ST_ERR: begin
          err   <= err_next;
          state <= ST_SUM;
        end
        ST_SUM: begin
          valid[ptr] <= 1'b1;
          ptr        <= (ptr == PTR_LAST) ? '0 : ptr + 1'b1;
          sum        <= sum_next;
          diff       <= DIFF_W'(err) - DIFF_W'(prev);
          done       <= abs_err <= (pwic_pkg::ERR_W+1)'(regs.stop_band);
          state      <= ST_MAG;
        end
        ST_MAG: begin
          mag   <= mag_next;
          acc   <= ACC_W'(prod);
          state <= ST_RCP;
        end
        ST_RCP: begin
          acc   <= acc + ACC_W'(prod);
          state <= ST_FIX;
        end
        ST_FIX: begin
          quot  <= quot_next;
          state <= ST_MULI;
        end
        ST_MULI: begin
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            res.drive_command <= cmd_next;
            res.move_done     <= done;
            res.current_error <= err;
            prev              <= err;
            state             <= ST_LOAD;
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

endmodule

[rtl/pid_windowed_integral_controller.sv]
// Windowed-integral PID distance controller. Each request carries one wheel
// position sample (signed Q16.16 revolutions) and a first-sample flag; each
// gives exactly one result: a drive command in whole percent (-100..100,
// truncated toward zero, then clamped), a done flag (|error| <= stop band)
// and the saturated Q16.8 error. The integral term uses the mean of the last
// WINDOW errors, held in a small RAM with per-entry valid bits, so a first
// sample restarts the window at once and no clearing pass is needed after
// reset. From leaving the request queue to its result being registered, a
// sample's steps follow the sequence of five products on the one shared
// multiplier (distance, P, D, reciprocal for the mean, I); intake runs ahead
// through a two-entry queue, and a waiting result holds only the final step.
// Register writes are accepted at once and are to be made while no request is
// in flight; an index above the last register is ignored.
module pid_windowed_integral_controller #(
  parameter int WINDOW = 25
) (
  input  logic        clk,
  input  logic        rst,
  pwic_in_if.sink     in_ch,
  pwic_out_if.source  out_ch,
  pwic_cfg_if.sink    cfg
);

  pwic_pkg::cfg_t regs;
  pwic_pkg::req_t push_req;
  pwic_pkg::req_t head;
  pwic_pkg::res_t res;
  logic           push;
  logic           q_full;
  logic           head_valid;
  logic           pop;
  logic           res_valid;

  pwic_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .cfg      (cfg),
    .q_full   (q_full),
    .push     (push),
    .push_req (push_req),
    .regs     (regs)
  );

  pwic_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_req   (push_req),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  pwic_back #(
    .WINDOW (WINDOW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .regs      (regs),
    .q_valid   (head_valid),
    .q_req     (head),
    .q_pop     (pop),
    .res_valid (res_valid),
    .res_ready (out_ch.ready),
    .res       (res)
  );

  // result channel
  assign out_ch.valid         = res_valid;
  assign out_ch.drive_command = res.drive_command;
  assign out_ch.move_done     = res.move_done;
  assign out_ch.current_error = res.current_error;

endmodule

[rtl/pwic_checker.sv]
`include "pid_windowed_integral_controller_macros.svh"

// Port-level checks on the controller.
module pwic_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [pwic_pkg::CMD_W-1:0] drive_command,
  input logic                              move_done,
  input logic signed [pwic_pkg::ERR_W-1:0] current_error
);

  // requests taken but not yet answered
  logic [2:0] pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if ((in_valid && in_ready) && !(out_valid && out_ready)) begin
      pending <= pending + 1'b1;
    end else if (!(in_valid && in_ready) && (out_valid && out_ready)) begin
      pending <= pending - 1'b1;
    end
  end

  `PWIC_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `PWIC_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && !out_ready, $stable(drive_command) && $stable(move_done) && $stable(current_error), "result changed while stalled")
  `PWIC_ASSERT_NOW(a_cmd_range, clk, rst, out_valid, (drive_command >= -8'sd100) && (drive_command <= 8'sd100), "drive command out of range")
  `PWIC_ASSERT_NOW(a_no_orphan, clk, rst, out_valid, pending != 3'd0, "result with no request outstanding")

endmodule

bind pid_windowed_integral_controller pwic_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .drive_command (out_ch.drive_command),
  .move_done     (out_ch.move_done),
  .current_error (out_ch.current_error)
);

[sim/pwic_checker.sv]
`timescale 1ns / 100ps

// Watches the register, sample and result channels of the controller,
// keeps its own copy of the registers and the error window, and compares
// every result with the oldest predicted one.
module pwic_scoreboard #(
  parameter int WINDOW = 25
) (
  input  logic clk,
  input  logic rst,
  pwic_in_if   in_ch,
  pwic_out_if  out_ch,
  pwic_cfg_if  cfg,
  output int   fail_count,
  output int   outstanding
);

  // shadow registers and controller state
  pwic_pkg::cfg_t                    regs;
  logic signed [pwic_pkg::ERR_W-1:0] err_ring [WINDOW];
  longint                            ring_sum;
  int                                ring_ptr;
  logic signed [pwic_pkg::ERR_W-1:0] last_err;

  pwic_pkg::res_t expected_drive_q[$];
  pwic_pkg::res_t want;

  // one control tick: error, window mean and clamped PID command
  function automatic pwic_pkg::res_t predict_drive(
      input logic signed [pwic_pkg::REVS_W-1:0] revs, input logic first);
    longint         target, distance, err, mean, acc, cmd, mag;
    pwic_pkg::res_t r;
    target = longint'(regs.target);
    if (first) begin
      foreach (err_ring[i]) err_ring[i] = '0;
      ring_sum = 0;
      ring_ptr = 0;
      last_err = regs.target;
    end
    // Q16.16 * Q8.8, floor back to Q16.8
    distance = (longint'(revs) * longint'(regs.travel_per_rev)) >>> pwic_pkg::FRAC_W;
    err      = target - distance;
    if (err > longint'(pwic_pkg::ERR_MAX)) err = longint'(pwic_pkg::ERR_MAX);
    if (err < longint'(pwic_pkg::ERR_MIN)) err = longint'(pwic_pkg::ERR_MIN);
    // replace the oldest window entry
    ring_sum -= longint'(err_ring[ring_ptr]);
    err_ring[ring_ptr] = pwic_pkg::ERR_W'(err);
    ring_sum += err;
    ring_ptr = (ring_ptr + 1) % WINDOW;
    mean = ring_sum / WINDOW;
    acc = longint'(regs.gain_p) * err
        + longint'(regs.gain_i) * mean
        + longint'(regs.gain_d) * (err - longint'(last_err));
    cmd = acc / 65536;
    if (cmd > longint'(pwic_pkg::CMD_LIMIT)) cmd = longint'(pwic_pkg::CMD_LIMIT);
    if (cmd < -longint'(pwic_pkg::CMD_LIMIT)) cmd = -longint'(pwic_pkg::CMD_LIMIT);
    last_err = pwic_pkg::ERR_W'(err);
    mag = (err < 0) ? -err : err;
    r.drive_command = pwic_pkg::CMD_W'(cmd);
    r.move_done     = (mag <= longint'(regs.stop_band));
    r.current_error = pwic_pkg::ERR_W'(err);
    return r;
  endfunction

  task automatic check_field(input string field, input logic signed [31:0] exp_v,
                             input logic signed [31:0] got_v);
    if (got_v !== exp_v) begin
      fail_count++;
      $error("%s: expected %0d, got %0d", field, exp_v, got_v);
    end
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    if (rst) begin
      regs.target         = pwic_pkg::TARGET_RST;
      regs.stop_band      = pwic_pkg::STOP_RST;
      regs.gain_p         = pwic_pkg::GAIN_P_RST;
      regs.gain_i         = pwic_pkg::GAIN_I_RST;
      regs.gain_d         = pwic_pkg::GAIN_D_RST;
      regs.travel_per_rev = pwic_pkg::TRAVEL_RST;
      foreach (err_ring[i]) err_ring[i] = '0;
      ring_sum = 0;
      ring_ptr = 0;
      last_err = '0;
      expected_drive_q.delete();
    end else begin
      // register writes; spare indexes fall through
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          pwic_pkg::CFG_TARGET: regs.target         = cfg.data[pwic_pkg::ERR_W-1:0];
          pwic_pkg::CFG_STOP:   regs.stop_band      = cfg.data[pwic_pkg::STOP_W-1:0];
          pwic_pkg::CFG_GAIN_P: regs.gain_p         = cfg.data[pwic_pkg::GAIN_W-1:0];
          pwic_pkg::CFG_GAIN_I: regs.gain_i         = cfg.data[pwic_pkg::GAIN_W-1:0];
          pwic_pkg::CFG_GAIN_D: regs.gain_d         = cfg.data[pwic_pkg::GAIN_W-1:0];
          pwic_pkg::CFG_TRAVEL: regs.travel_per_rev = cfg.data[pwic_pkg::GAIN_W-1:0];
          default: ;
        endcase
      end
      // results against the oldest prediction
      if (out_ch.valid && out_ch.ready) begin
        if (expected_drive_q.size() == 0) begin
          fail_count++;
          $error("result with no request outstanding: drive_command %0d",
                 out_ch.drive_command);
        end else begin
          want = expected_drive_q.pop_front();
          check_field("drive_command", want.drive_command, out_ch.drive_command);
          check_field("move_done", want.move_done, out_ch.move_done);
          check_field("current_error", want.current_error, out_ch.current_error);
        end
      end
      // accepted samples
      if (in_ch.valid && in_ch.ready)
        expected_drive_q.insert(expected_drive_q.size(),
                                predict_drive(in_ch.measured_revs, in_ch.first_sample));
    end
    outstanding <= expected_drive_q.size();
  end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

  localparam int WINDOW    = 25;
  localparam int RUN_LIMIT = 400000;
  localparam int SETTLE    = 16;
  localparam int PHASES    = 10;
  localparam int PHASE_LEN = 55;
  // indexes past the last register
  localparam logic [pwic_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [pwic_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
  localparam longint REVS_HI = 64'sd2147483647;
  localparam longint REVS_LO = -64'sd2147483648;
  // directed done-band target, 24 in
  localparam int BAND_TGT = 6144;

  logic clk;
  logic rst;
  int   fail_count;
  int   outstanding;
  int   cycles;
  int   burst_left;
  int   gap_max;
  int   samples_sent;
  int   stall_mode;
  int   stall_left;
  int   phase;
  int   phase_start;

  logic signed [pwic_pkg::ERR_W-1:0] tgt;
  logic [pwic_pkg::GAIN_W-1:0]       trav;

  pwic_in_if  in_ch ();
  pwic_out_if out_ch ();
  pwic_cfg_if cfg ();

  pid_windowed_integral_controller #(.WINDOW(WINDOW)) dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg)
  );

  pwic_scoreboard #(.WINDOW(WINDOW)) u_scoreboard (
    .clk         (clk),
    .rst         (rst),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg         (cfg),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    cycles = 0;
    while (cycles < RUN_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  // result back-pressure: free flow, coin flips, sparse accepts, long holds
  initial begin
    out_ch.ready = 1'b0;
    stall_left = 0;
    stall_mode = 0;
    forever begin
      @(posedge clk);
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(1, 60);
      end
      stall_left--;
      case (stall_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= 1'($urandom_range(0, 1));
        2: out_ch.ready <= ($urandom_range(0, 7) == 0);
        default: out_ch.ready <= (stall_left < 4);
      endcase
    end
  end

  function automatic logic signed [pwic_pkg::REVS_W-1:0] fit_revs(input longint v);
    if (v > REVS_HI) return pwic_pkg::REVS_W'(REVS_HI);
    if (v < REVS_LO) return pwic_pkg::REVS_W'(REVS_LO);
    return pwic_pkg::REVS_W'(v);
  endfunction

  // mostly moderate gains, now and then an extreme
  function automatic logic [pwic_pkg::GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return pwic_pkg::GAIN_W'($urandom_range(0, 8000));
    endcase
  endfunction

  // one sample request; bursts and gaps are decided here
  task automatic send_sample(input logic signed [pwic_pkg::REVS_W-1:0] revs,
                             input logic first);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (gap_max > 0) begin
        gap = $urandom_range(0, gap_max);
        if (gap > 0) begin
          in_ch.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
    burst_left--;
    in_ch.valid         <= 1'b1;
    in_ch.measured_revs <= revs;
    in_ch.first_sample  <= first;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    samples_sent++;
  endtask

  task automatic write_reg(input logic [pwic_pkg::CFG_IDX_W-1:0] idx,
                           input logic [pwic_pkg::CFG_DATA_W-1:0] data);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= data;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_regs(input logic [pwic_pkg::CFG_DATA_W-1:0] target,
                           input logic [pwic_pkg::CFG_DATA_W-1:0] stop,
                           input logic [pwic_pkg::GAIN_W-1:0] gp,
                           input logic [pwic_pkg::GAIN_W-1:0] gi,
                           input logic [pwic_pkg::GAIN_W-1:0] gd,
                           input logic [pwic_pkg::GAIN_W-1:0] travel);
    write_reg(pwic_pkg::CFG_TARGET, target);
    write_reg(pwic_pkg::CFG_STOP, stop);
    write_reg(pwic_pkg::CFG_GAIN_P, pwic_pkg::CFG_DATA_W'(gp));
    write_reg(pwic_pkg::CFG_GAIN_I, pwic_pkg::CFG_DATA_W'(gi));
    write_reg(pwic_pkg::CFG_GAIN_D, pwic_pkg::CFG_DATA_W'(gd));
    write_reg(pwic_pkg::CFG_TRAVEL, pwic_pkg::CFG_DATA_W'(travel));
  endtask

  // hold off new samples until every result is back and the pipe is empty
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // one move: restart at rest, then creep towards the goal with jitter,
  // sprinkled with stray positions and stray restarts
  task automatic run_move(input longint target_q, input longint travel_q, input int steps);
    longint goal, pos, jit;
    int     k;
    if (travel_q == 0) goal = longint'($signed($urandom));
    else goal = (target_q * 65536) / travel_q;
    goal = longint'(fit_revs(goal));
    jit = (goal < 0) ? -goal / 16 : goal / 16;
    jit += 64;
    send_sample(fit_revs(longint'($urandom_range(0, 64)) - 32), 1'b1);
    for (k = 1; k <= steps; k++) begin
      if ($urandom_range(0, 9) == 0) begin
        send_sample($urandom, $urandom_range(0, 3) == 0);
      end else begin
        pos = (goal * k) / steps + longint'($urandom_range(0, 2 * jit)) - jit;
        send_sample(fit_revs(pos), 1'b0);
      end
    end
  endtask

  initial begin
    rst                 = 1'b1;
    in_ch.valid         = 1'b0;
    in_ch.measured_revs = '0;
    in_ch.first_sample  = 1'b0;
    cfg.valid           = 1'b0;
    cfg.index           = '0;
    cfg.data            = '0;
    burst_left          = 0;
    gap_max             = 0;
    samples_sent        = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset registers: zero, floor of negative distance, error saturation
    send_sample('0, 1'b1);
    send_sample(32'sd1, 1'b0);
    send_sample(-32'sd1, 1'b0);
    send_sample(32'sh7FFFFFFF, 1'b0);
    send_sample(32'sh80000000, 1'b0);
    send_sample('0, 1'b0);
    wait_idle();

    // maximum target, all-ones gains and travel, stop band written past its width, spare indexes
    load_regs(24'h7FFFFF, 24'hFFFFFF, '1, '1, '1, '1);
    write_reg(CFG_SPARE_LO, 24'h000001);
    write_reg(CFG_SPARE_HI, 24'hFFFFFF);
    send_sample('0, 1'b1);
    send_sample(32'sh7FFFFFFF, 1'b0);
    send_sample(32'sh80000000, 1'b0);
    send_sample(32'sh00010000, 1'b0);
    wait_idle();

    // most negative target, zero gains, zero band and zero travel
    load_regs(24'h800000, '0, '0, '0, '0, '0);
    send_sample($urandom, 1'b1);
    send_sample('0, 1'b0);
    wait_idle();

    // unit travel: error lands on and just past the done band both ways
    load_regs(pwic_pkg::CFG_DATA_W'(BAND_TGT), pwic_pkg::CFG_DATA_W'(256),
              pwic_pkg::GAIN_P_RST, pwic_pkg::GAIN_I_RST, pwic_pkg::GAIN_D_RST, 16'd256);
    send_sample('0, 1'b1);
    send_sample((BAND_TGT - 256) * 256, 1'b0);
    send_sample((BAND_TGT - 257) * 256, 1'b0);
    send_sample((BAND_TGT + 256) * 256, 1'b0);
    send_sample((BAND_TGT + 257) * 256, 1'b0);
    wait_idle();

    // random phases, each with its own register set
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          tgt  = pwic_pkg::ERR_MAX;
          trav = '1;
          load_regs(tgt, '0, '1, '1, '1, trav);
        end
        1: begin
          tgt  = pwic_pkg::ERR_MIN;
          trav = 16'd1;
          load_regs(tgt, 24'h7FFFFF, '0, '0, '0, trav);
        end
        default: begin
          if ($urandom_range(0, 5) == 0) tgt = pwic_pkg::ERR_W'($urandom);
          else tgt = pwic_pkg::ERR_W'(int'($urandom_range(0, 96 * 256)) - 48 * 256);
          case ($urandom_range(0, 7))
            0: trav = '0;
            1: trav = '1;
            default: trav = pwic_pkg::GAIN_W'($urandom_range(1000, 4000));
          endcase
          load_regs(tgt,
                    ($urandom_range(0, 4) == 0)
                      ? pwic_pkg::CFG_DATA_W'($urandom)
                      : pwic_pkg::CFG_DATA_W'($urandom_range(0, 1024)),
                    pick_gain(), pick_gain(), pick_gain(), trav);
          if ($urandom_range(0, 2) == 0)
            write_reg(CFG_SPARE_LO, pwic_pkg::CFG_DATA_W'($urandom));
        end
      endcase
      gap_max = (phase % 3 == 0) ? 0 : $urandom_range(3, 20);
      phase_start = samples_sent;
      while (samples_sent - phase_start < PHASE_LEN) begin
        run_move(longint'(tgt), longint'(trav), $urandom_range(5, 60));
        if ($urandom_range(0, 5) == 0) wait_idle();
      end
      wait_idle();
    end

    if (fail_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/pwic_pkg.sv
rtl/pwic_in_if.sv
rtl/pwic_out_if.sv
rtl/pwic_cfg_if.sv
rtl/pwic_ram.sv
rtl/pwic_front.sv
rtl/pwic_queue.sv
rtl/pwic_back.sv
rtl/pid_windowed_integral_controller.sv
rtl/pwic_checker.sv
sim/pwic_checker.sv
sim/tb_top.sv
